// ----- rtl/core/file_type_sniffer_defines.svh -----
// Assertion macros shared by the file type sniffer RTL.
`ifndef FILE_TYPE_SNIFFER_DEFINES_SVH
`define FILE_TYPE_SNIFFER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define FTS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("fts: invariant violated");

// When ante holds, cons must hold in the next cycle.
`define FTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fts: next-cycle check failed");

`endif

// ----- rtl/core/fts_pkg.sv -----
// Package for the file type sniffer: sizes, kind codes and shared structs.
package fts_pkg;

    localparam int TEXT_WINDOW = 256;
    localparam int HEAD_LEN    = 12;
    localparam int CNT_W       = $clog2(TEXT_WINDOW + 1);

    typedef logic [CNT_W-1:0] count_t;

    localparam count_t WINDOW_CNT = count_t'(TEXT_WINDOW);

    typedef enum logic [2:0] {
        KIND_UNKNOWN  = 3'd0,
        KIND_IMAGE    = 3'd1,
        KIND_AUDIO    = 3'd2,
        KIND_VIDEO    = 3'd3,
        KIND_DOCUMENT = 3'd4,
        KIND_ARCHIVE  = 3'd5,
        KIND_TEXT     = 3'd6,
        KIND_BINARY   = 3'd7
    } kind_t;

    // Held beat moving into the tracker, with its advance strobe.
    typedef struct packed {
        logic       fire;
        logic [7:0] data_byte;
        logic       last;
    } step_t;

    // Stream statistics including the beat being retired.
    typedef struct packed {
        logic [HEAD_LEN-1:0][7:0] head;
        count_t                   total;
        count_t                   printable;
    } summary_t;

endpackage

// ----- rtl/core/fts_in_if.sv -----
// Input channel: one file byte per beat with an end-of-file flag.
interface fts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ----- rtl/core/fts_out_if.sv -----
// Output channel: one kind code per beat.
interface fts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] file_kind;

    modport source (output valid, output file_kind, input ready);
    modport sink   (input valid, input file_kind, output ready);
endinterface

// ----- rtl/core/fts_in_stage.sv -----
// Input register for the byte stream and advance control.
module fts_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    fts_in_if.sink         stream,
    input  logic           slot_free,
    output fts_pkg::step_t step
);
    import fts_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;

    // Plain bytes always move on; a final byte waits for the result slot.
    assign advance      = valid_reg && (!last_reg || slot_free);
    assign stream.ready = !valid_reg || advance;

    assign step.fire      = advance;
    assign step.data_byte = byte_reg;
    assign step.last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            byte_reg <= stream.data_byte;
            last_reg <= stream.last;
        end
    end

endmodule

// ----- rtl/core/fts_track.sv -----
// Per-stream state: header bytes, saturating byte count, printable count.
`include "file_type_sniffer_defines.svh"

module fts_track (
    input  logic              clk,
    input  logic              rst_n,
    input  fts_pkg::step_t    step,
    output fts_pkg::summary_t summary
);
    import fts_pkg::*;

    logic [HEAD_LEN-1:0][7:0] head_reg, head_next;
    count_t                   count_reg, count_next;
    count_t                   print_reg, print_next;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= 8'd32 && b <= 8'd126) || b == 8'd10 || b == 8'd13 || b == 8'd9;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        print_next = print_reg;
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            if (count_reg == count_t'(i))
            begin
                head_next[i] = step.data_byte;
            end
        end
        if (count_reg < WINDOW_CNT)
        begin
            if (is_printable(step.data_byte))
            begin
                print_next = print_reg + count_t'(1);
            end
            count_next = count_reg + count_t'(1);
        end
    end

    assign summary.head      = head_next;
    assign summary.total     = count_next;
    assign summary.printable = print_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            print_reg <= '0;
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                head_reg  <= '0;
                count_reg <= '0;
                print_reg <= '0;
            end
            else
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                print_reg <= print_next;
            end
        end
    end

    `FTS_ASSERT_NEXT(a_end_clears, clk, rst_n, step.fire && step.last, count_reg == '0 && print_reg == '0)
    `FTS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= WINDOW_CNT)
    `FTS_ASSERT_ALWAYS(a_print_bound, clk, rst_n, print_reg <= count_reg)

endmodule

// ----- rtl/core/fts_classify.sv -----
// Signature match and text/binary decision into the result register.
`include "file_type_sniffer_defines.svh"

module fts_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  fts_pkg::step_t    step,
    input  fts_pkg::summary_t summary,
    output logic              slot_free,
    fts_out_if.source         result
);
    import fts_pkg::*;

    logic                     valid_reg;
    kind_t                    kind_reg;
    kind_t                    kind_next;
    logic [HEAD_LEN-1:0][7:0] h;
    logic                     has3, has4, has6, has8, has12;
    logic                     png, gif, jpeg, webp, audio, video, pdf, zip;
    logic [CNT_W+3:0]         p10, t9;

    assign h     = summary.head;
    assign has3  = summary.total >= count_t'(3);
    assign has4  = summary.total >= count_t'(4);
    assign has6  = summary.total >= count_t'(6);
    assign has8  = summary.total >= count_t'(8);
    assign has12 = summary.total >= count_t'(12);

    always_comb
    begin
        png   = has8 && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E && h[3] == 8'h47
                && h[4] == 8'h0D && h[5] == 8'h0A && h[6] == 8'h1A && h[7] == 8'h0A;
        // GIF87a / GIF89a
        gif   = has6 && h[0] == 8'h47 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h38
                && (h[4] == 8'h37 || h[4] == 8'h39) && h[5] == 8'h61;
        // FF D8 FF, or bare JFIF / Exif tags at the start
        jpeg  = (has3 && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF)
                || (has4 && h[0] == 8'h4A && h[1] == 8'h46 && h[2] == 8'h49 && h[3] == 8'h46)
                || (has4 && h[0] == 8'h45 && h[1] == 8'h78 && h[2] == 8'h69 && h[3] == 8'h66);
        webp  = has12 && h[0] == 8'h52 && h[1] == 8'h49 && h[2] == 8'h46 && h[3] == 8'h46
                && h[8] == 8'h57 && h[9] == 8'h45 && h[10] == 8'h42 && h[11] == 8'h50;
        // ID3, MP3 frame sync, OggS
        audio = (has3 && h[0] == 8'h49 && h[1] == 8'h44 && h[2] == 8'h33)
                || (h[0] == 8'hFF && (h[1] == 8'hFB || h[1] == 8'hFA))
                || (has4 && h[0] == 8'h4F && h[1] == 8'h67 && h[2] == 8'h67 && h[3] == 8'h53);
        video = has8 && h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h00
                && h[4] == 8'h66 && h[5] == 8'h74 && h[6] == 8'h79 && h[7] == 8'h70;
        pdf   = has4 && h[0] == 8'h25 && h[1] == 8'h50 && h[2] == 8'h44 && h[3] == 8'h46;
        zip   = has4 && h[0] == 8'h50 && h[1] == 8'h4B
                && ((h[2] == 8'h03 && h[3] == 8'h04) || (h[2] == 8'h05 && h[3] == 8'h06));
    end

    // 10*printable vs 9*checked by shift-add.
    assign p10 = ({4'b0, summary.printable} << 3) + ({4'b0, summary.printable} << 1);
    assign t9  = ({4'b0, summary.total} << 3) + {4'b0, summary.total};

    always_comb
    begin
        if (!has4)
            kind_next = KIND_UNKNOWN;
        else if (png || gif || jpeg || webp)
            kind_next = KIND_IMAGE;
        else if (audio)
            kind_next = KIND_AUDIO;
        else if (video)
            kind_next = KIND_VIDEO;
        else if (pdf)
            kind_next = KIND_DOCUMENT;
        else if (zip)
            kind_next = KIND_ARCHIVE;
        else if (p10 > t9)
            kind_next = KIND_TEXT;
        else
            kind_next = KIND_BINARY;
    end

    assign slot_free        = !valid_reg || result.ready;
    assign result.valid     = valid_reg;
    assign result.file_kind = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step.fire && step.last)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire && step.last)
        begin
            kind_reg <= kind_next;
        end
    end

    `FTS_ASSERT_NEXT(a_end_gives_result, clk, rst_n, step.fire && step.last, valid_reg)
    `FTS_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(step.fire && step.last) || slot_free)

endmodule

// ----- rtl/core/file_type_sniffer.sv -----
// Top level of the file type sniffer: magic-number file kind detection.
// Throughput: one byte beat per cycle, no gaps between files, while the output is not stalled.
// The final byte's beat is held in the input register; its kind code then goes into the result
// register, which drives the result valid flag.
// A final byte is held in the input register while the result register is still full.
// Reset (rst_n low, async): clears the beat and result valid flags, counters and header buffer.
module file_type_sniffer (
    input  logic       clk,
    input  logic       rst_n,
    fts_in_if.sink     stream,
    fts_out_if.source  result
);
    import fts_pkg::*;

    // step: the held beat and its advance strobe.  Plain bytes advance every
    // cycle; only the final byte of a file needs room in the result register.
    step_t    step;
    summary_t summary;
    logic     slot_free;

    // Input register: holds each beat; stream ready still follows result ready while a final byte waits.
    fts_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .slot_free (slot_free),
        .step      (step)
    );

    // Stream state: first twelve bytes plus counters over the text window.
    // Its summary already folds in the beat being retired, so the decision
    // on the final byte sees the complete stream.
    fts_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .summary (summary)
    );

    // Signature priority chain and text ratio test, then the result register.
    fts_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .summary   (summary),
        .slot_free (slot_free),
        .result    (result)
    );

endmodule
